// ===== design/cfgrad_pkg.sv =====
// Package: shared types and constants for the color forward gradient block.
package cfgrad_pkg;

  // Fixed field widths
  localparam int GAIN_W  = 16;
  localparam int SCALE_W = 13;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 11;
  localparam int RES_W   = 32;
  localparam int WREG_W  = 12;
  localparam int HREG_W  = 13;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Frame limits and register reset values
  localparam int MAX_HEIGHT   = 4096;
  localparam int GAIN_RESET   = 4096;
  localparam int WIDTH_RESET  = 2048;
  localparam int HEIGHT_RESET = 4096;

  // Register index on the configuration bus
  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_SPACING = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } reg_idx_t;

  // Position and flags that travel with each result
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } tag_t;

  // Load enables of the scaling pipeline stages
  typedef struct packed {
    logic e1;
    logic e2;
    logic e3;
    logic eo;
  } stage_en_t;

endpackage

// ===== design/cfgrad_scale.sv =====
// Module: scaling pipeline for one difference (gain, spacing, round, saturate).
module cfgrad_scale #(
  parameter int DIFF_W    = 19,
  parameter int FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  cfgrad_pkg::stage_en_t                 en,
  input  logic signed [DIFF_W-1:0]              diff_i,
  input  logic signed [cfgrad_pkg::GAIN_W-1:0]  gain_i,
  input  logic        [cfgrad_pkg::SCALE_W-1:0] scale_i,
  output logic signed [cfgrad_pkg::RES_W-1:0]   res_o
);
  import cfgrad_pkg::*;

  localparam int GP_W = DIFF_W + GAIN_W;
  localparam int SP_W = GP_W + SCALE_W + 1;
  localparam int EW   = (SP_W + 1 > RES_W + 1) ? SP_W + 1 : RES_W + 1;
  localparam logic signed [EW-1:0] HALF = EW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] QMAX = EW'(32'sh7FFFFFFF);
  localparam logic signed [EW-1:0] QMIN = EW'(32'sh80000000);

  logic signed [DIFF_W-1:0] diff_r;
  logic signed [GP_W-1:0]   gp_r;
  logic signed [SP_W-1:0]   sp_r;
  logic signed [RES_W-1:0]  res_r;
  logic signed [RES_W-1:0]  res_nxt;
  logic signed [EW-1:0]     sum;
  logic signed [EW-1:0]     quot;

  // Round to nearest, ties up, then clamp to 32 bits
  always_comb begin
    sum  = EW'(sp_r) + HALF;
    quot = sum >>> FRAC_BITS;
    if (quot > QMAX) begin
      res_nxt = RES_W'(QMAX);
    end else if (quot < QMIN) begin
      res_nxt = RES_W'(QMIN);
    end else begin
      res_nxt = quot[RES_W-1:0];
    end
  end

  // Advance each stage on its own enable
  always_ff @(posedge clk) begin
    if (en.e1) begin
      diff_r <= diff_i;
    end
    if (en.e2) begin
      gp_r <= diff_r * gain_i;
    end
    if (en.e3) begin
      sp_r <= gp_r * $signed({1'b0, scale_i});
    end
    if (en.eo) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ===== design/color_forward_gradient.sv =====
// Top level: streamed forward-difference RGB gradient with line buffer.
//
// Usage: RGB pixels enter in raster order on the in_ channel (valid/ready),
// one row width of pixels per row and one frame height of rows per frame. Each
// result on the out_ channel carries the scaled down and right differences of
// one pixel, with its row and column; results of row r come out while row r+1
// enters, and inputs of the last row also flush that row.
// Throughput: one input per cycle while each input makes at most one
// result and out_ready stays high; a last-row input is held until all the
// results it makes (two, or three at the final pixel) have been issued,
// since the single output channel moves one result per cycle. An input
// reaches out_valid through the pixel register, difference register, gain
// product, spacing product and round/saturate in the output register.
// The line buffer is a MAX_WIDTH-entry memory with one write and one read
// port; the next entry is fetched ahead so both neighbors of a column are
// on hand without a second read port.
// Reset (rst_n low, synchronous) empties the pipeline, restarts the frame
// at row 0, column 0 and loads the register defaults. No clearing pass.
// When the receiver stalls, the pipeline stages fill up one after another
// and in_ready drops only once the stage holding the pixel is blocked.
// Registers go through the cfg_ port: gain at 0x0, use_spacing at 0x4,
// row width at 0x8, frame height at 0xC; write them only while idle.
module color_forward_gradient #(
  parameter int MAX_WIDTH      = 2048,
  parameter int SAMPLE_BITS    = 18,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input pixel channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_red_in,
  input  logic signed [SAMPLE_BITS-1:0]        in_green_in,
  input  logic signed [SAMPLE_BITS-1:0]        in_blue_in,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [cfgrad_pkg::ROW_W-1:0]  out_row,
  output logic        [cfgrad_pkg::COL_W-1:0]  out_col,
  output logic signed [cfgrad_pkg::RES_W-1:0]  out_red_down,
  output logic signed [cfgrad_pkg::RES_W-1:0]  out_red_right,
  output logic signed [cfgrad_pkg::RES_W-1:0]  out_green_down,
  output logic signed [cfgrad_pkg::RES_W-1:0]  out_green_right,
  output logic signed [cfgrad_pkg::RES_W-1:0]  out_blue_down,
  output logic signed [cfgrad_pkg::RES_W-1:0]  out_blue_right,
  output logic                                 out_run_last,
  output logic                                 out_frame_done,
  // Configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic        [cfgrad_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic        [cfgrad_pkg::DATA_W-1:0] cfg_pwdata,
  output logic        [cfgrad_pkg::DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import cfgrad_pkg::*;

  localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = ((CW > WREG_W) ? CW : WREG_W) + 1;
  localparam int DW   = SAMPLE_BITS + 1;
  localparam int WLIM = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam logic [WREG_W-1:0] WLIM_V = WREG_W'(WLIM);
  localparam logic [HREG_W-1:0] HLIM_V = HREG_W'(MAX_HEIGHT);

  typedef logic [2:0][SAMPLE_BITS-1:0] pix_t;

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_r;
  logic                     spacing_r;
  logic [WREG_W-1:0]        width_r;
  logic [HREG_W-1:0]        height_r;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  // Frame position
  logic [ROW_W-1:0]  row_r, row_nxt, r_cur;
  logic [CW-1:0]     col_r, col_nxt, c_cur;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic [SCALE_W-1:0] sv, sh;
  logic [CMPW-1:0]   c_inc;
  logic              c_last, r_last, out_of_range;
  logic [CW-1:0]     rd_addr;
  logic              in_fire;
  pix_t              in_pix;

  // Line buffer
  pix_t mem_r [MAX_WIDTH];
  pix_t mem_rd_r;
  logic byp_r;
  pix_t old_next;

  // Pixel stage
  logic [2:0]       s1_pend_r, pend_clr;
  pix_t             s1_pix_r, s1_prev_r, s1_oldc_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_rz_r;
  logic             iss, iss_last;
  tag_t             iss_tag;
  logic signed [DW-1:0] iss_down  [3];
  logic signed [DW-1:0] iss_right [3];

  // Scaling pipeline control
  logic      e1_v_r, e2_v_r, e3_v_r, out_v_r;
  tag_t      e1_tag_r, e2_tag_r, e3_tag_r, out_tag_r;
  logic      e1_ld, e2_ld, e3_ld, eo_ld;
  stage_en_t st_en;
  logic signed [RES_W-1:0] res_down  [3];
  logic signed [RES_W-1:0] res_right [3];

  // Decode register writes; pready is never held low
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_W'(GAIN_RESET);
      spacing_r <= 1'b0;
      width_r   <= WREG_W'(WIDTH_RESET);
      height_r  <= HREG_W'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN:    gain_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_SPACING: spacing_r <= cfg_pwdata[0];
        REG_WIDTH:   width_r   <= cfg_pwdata[WREG_W-1:0];
        REG_HEIGHT:  height_r  <= cfg_pwdata[HREG_W-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_GAIN:    cfg_prdata = {{(DATA_W-GAIN_W){gain_r[GAIN_W-1]}}, gain_r};
      REG_SPACING: cfg_prdata = {{(DATA_W-1){1'b0}}, spacing_r};
      REG_WIDTH:   cfg_prdata = {{(DATA_W-WREG_W){1'b0}}, width_r};
      REG_HEIGHT:  cfg_prdata = {{(DATA_W-HREG_W){1'b0}}, height_r};
    endcase
  end

  // Clamp frame size and pick spacing factors
  always_comb begin
    if (width_r == '0) begin
      w_eff = WREG_W'(1);
    end else if (width_r > WLIM_V) begin
      w_eff = WLIM_V;
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HREG_W'(1);
    end else if (height_r > HLIM_V) begin
      h_eff = HLIM_V;
    end else begin
      h_eff = height_r;
    end
    sv = spacing_r ? h_eff : SCALE_W'(1);
    sh = spacing_r ? SCALE_W'(w_eff) : SCALE_W'(1);
  end

  // Locate the incoming pixel and plan the next position and fetch
  assign in_pix = {in_blue_in, in_green_in, in_red_in};
  assign in_fire = in_valid && in_ready;

  always_comb begin
    out_of_range = (HREG_W'(row_r) >= h_eff) || (CMPW'(col_r) >= CMPW'(w_eff));
    r_cur  = out_of_range ? '0 : row_r;
    c_cur  = out_of_range ? '0 : col_r;
    c_inc  = CMPW'(c_cur) + CMPW'(1);
    c_last = (c_inc == CMPW'(w_eff));
    r_last = ((HREG_W'(r_cur) + HREG_W'(1)) == h_eff);
    rd_addr = c_last ? '0 : c_inc[CW-1:0];
    col_nxt = c_last ? '0 : c_inc[CW-1:0];
    if (!c_last) begin
      row_nxt = r_cur;
    end else if (r_last) begin
      row_nxt = '0;
    end else begin
      row_nxt = r_cur + ROW_W'(1);
    end
  end

  // Write the pixel and fetch the entry for the next column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_r[c_cur] <= in_pix;
      mem_rd_r     <= mem_r[rd_addr];
    end
  end

  // Single-column frame: the fetched entry is the one being written
  assign old_next = byp_r ? s1_pix_r : mem_rd_r;

  // Pick the pending result in order: upper row, left neighbor, final pixel
  assign pend_clr = s1_pend_r & (s1_pend_r - 3'd1);
  assign iss      = (s1_pend_r != '0) && e1_ld;
  assign iss_last = (pend_clr == '0);
  assign in_ready = (s1_pend_r == '0) || (iss && iss_last);

  always_comb begin
    iss_tag.last = iss_last;
    iss_tag.done = 1'b0;
    priority if (s1_pend_r[0]) begin
      iss_tag.row = s1_row_r - ROW_W'(1);
      iss_tag.col = COL_W'(s1_col_r);
      for (int k = 0; k < 3; k++) begin
        iss_down[k]  = $signed(s1_pix_r[k]) - $signed(s1_oldc_r[k]);
        iss_right[k] = $signed(mem_rd_r[k]) - $signed(s1_oldc_r[k]);
        // Last column has no right neighbor
        if (s1_rz_r) begin
          iss_right[k] = '0;
        end
      end
    end else if (s1_pend_r[1]) begin
      iss_tag.row = s1_row_r;
      iss_tag.col = COL_W'(s1_col_r - CW'(1));
      for (int k = 0; k < 3; k++) begin
        iss_down[k]  = '0;
        iss_right[k] = $signed(s1_pix_r[k]) - $signed(s1_prev_r[k]);
      end
    end else begin
      iss_tag.row  = s1_row_r;
      iss_tag.col  = COL_W'(s1_col_r);
      iss_tag.done = 1'b1;
      for (int k = 0; k < 3; k++) begin
        iss_down[k]  = '0;
        iss_right[k] = '0;
      end
    end
  end

  // Hold the pixel until all its results have gone down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      s1_pend_r <= '0;
      s1_pix_r  <= '0;
      s1_prev_r <= '0;
      byp_r     <= 1'b0;
    end else if (in_fire) begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      s1_pend_r <= {r_last && c_last, r_last && (c_cur != '0), r_cur != '0};
      s1_pix_r  <= in_pix;
      s1_prev_r <= s1_pix_r;
      byp_r     <= (rd_addr == c_cur);
    end else if (iss) begin
      s1_pend_r <= pend_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_oldc_r <= old_next;
      s1_row_r  <= r_cur;
      s1_col_r  <= c_cur;
      s1_rz_r   <= c_last;
    end
  end

  // Advance a stage when it is empty or the one after it moves
  assign eo_ld = !out_v_r || out_ready;
  assign e3_ld = !e3_v_r || eo_ld;
  assign e2_ld = !e2_v_r || e3_ld;
  assign e1_ld = !e1_v_r || e2_ld;
  assign st_en = '{e1: e1_ld, e2: e2_ld, e3: e3_ld, eo: eo_ld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r  <= 1'b0;
      e2_v_r  <= 1'b0;
      e3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (e1_ld) begin
        e1_v_r <= iss;
      end
      if (e2_ld) begin
        e2_v_r <= e1_v_r;
      end
      if (e3_ld) begin
        e3_v_r <= e2_v_r;
      end
      if (eo_ld) begin
        out_v_r <= e3_v_r;
      end
    end
  end

  // Carry position and flags alongside the products
  always_ff @(posedge clk) begin
    if (e1_ld) begin
      e1_tag_r <= iss_tag;
    end
    if (e2_ld) begin
      e2_tag_r <= e1_tag_r;
    end
    if (e3_ld) begin
      e3_tag_r <= e2_tag_r;
    end
    if (eo_ld) begin
      out_tag_r <= e3_tag_r;
    end
  end

  // One scaling pipeline per channel and direction
  for (genvar k = 0; k < 3; k++) begin : g_lane
    cfgrad_scale #(
      .DIFF_W   (DW),
      .FRAC_BITS(GAIN_FRAC_BITS)
    ) u_down (
      .clk    (clk),
      .en     (st_en),
      .diff_i (iss_down[k]),
      .gain_i (gain_r),
      .scale_i(sv),
      .res_o  (res_down[k])
    );
    cfgrad_scale #(
      .DIFF_W   (DW),
      .FRAC_BITS(GAIN_FRAC_BITS)
    ) u_right (
      .clk    (clk),
      .en     (st_en),
      .diff_i (iss_right[k]),
      .gain_i (gain_r),
      .scale_i(sh),
      .res_o  (res_right[k])
    );
  end

  // Drive the result channel from the output register
  assign out_valid       = out_v_r;
  assign out_row         = out_tag_r.row;
  assign out_col         = out_tag_r.col;
  assign out_run_last    = out_tag_r.last;
  assign out_frame_done  = out_tag_r.done;
  assign out_red_down    = res_down[0];
  assign out_red_right   = res_right[0];
  assign out_green_down  = res_down[1];
  assign out_green_right = res_right[1];
  assign out_blue_down   = res_down[2];
  assign out_blue_right  = res_right[2];

endmodule
